// ===== hw/rtl/cpe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_pkg
// Character codes, raw code values, types and coding functions for the
// Cologne phonetic encoder.
// ----------------------------------------------------------------------------
package cpe_pkg;

	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [7:0] CH_A = 8'h41, CH_B = 8'h42, CH_C = 8'h43, CH_D = 8'h44;
	localparam logic [7:0] CH_E = 8'h45, CH_F = 8'h46, CH_G = 8'h47, CH_H = 8'h48;
	localparam logic [7:0] CH_I = 8'h49, CH_J = 8'h4A, CH_K = 8'h4B, CH_L = 8'h4C;
	localparam logic [7:0] CH_M = 8'h4D, CH_N = 8'h4E, CH_O = 8'h4F, CH_P = 8'h50;
	localparam logic [7:0] CH_Q = 8'h51, CH_R = 8'h52, CH_S = 8'h53, CH_T = 8'h54;
	localparam logic [7:0] CH_U = 8'h55, CH_V = 8'h56, CH_W = 8'h57, CH_X = 8'h58;
	localparam logic [7:0] CH_Y = 8'h59, CH_Z = 8'h5A;

	localparam logic [3:0] RAW_H    = 4'd9;
	localparam logic [3:0] RAW_NONE = 4'd15;

	localparam int RES_SLOTS = 4;

	typedef struct packed {
		logic [1:0] cnt;
		logic [3:0] r0;
		logic [3:0] r1;
	} raw_pair_t;

	typedef struct packed {
		logic [3:0] last_raw;
		logic       first_seen;
		logic [3:0] held_digit;
		logic       held_valid;
	} filt_t;

	typedef struct packed {
		filt_t      st;
		logic       emit;
		logic [3:0] digit;
	} feed_out_t;

	typedef struct packed {
		logic [3:0] digit;
		logic       is_empty;
		logic       code_end;
	} result_t;

	localparam filt_t FILT_RESET = '{last_raw: RAW_NONE, first_seen: 1'b0,
		held_digit: 4'd0, held_valid: 1'b0};

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
			return c - CASE_OFS;
		end
		return c;
	endfunction

	function automatic raw_pair_t one_code(input logic [3:0] r);
		raw_pair_t o;
		o.cnt = 2'd1;
		o.r0  = r;
		o.r1  = 4'd0;
		return o;
	endfunction

	// raw codes of c in window (p, c, n)
	function automatic raw_pair_t code_char(input logic [7:0] p, input logic [7:0] c,
		input logic [7:0] n, input logic start);
		raw_pair_t o;
		o = '{cnt: 2'd0, r0: 4'd0, r1: 4'd0};
		if (start && c == CH_C) begin
			o = one_code((n == CH_A || n == CH_H || n == CH_K || n == CH_L || n == CH_O ||
				n == CH_Q || n == CH_R || n == CH_U || n == CH_X) ? 4'd4 : 4'd8);
		end else if (c == CH_P && n == CH_H) begin
			o = one_code(4'd3);
		end else if (c == CH_D || c == CH_T) begin
			o = one_code((n == CH_C || n == CH_S || n == CH_Z) ? 4'd8 : 4'd2);
		end else if (c == CH_X) begin
			if (p == CH_C || p == CH_K || p == CH_Q) begin
				o = one_code(4'd8);
			end else begin
				o = '{cnt: 2'd2, r0: 4'd4, r1: 4'd8};
			end
		end else if (c == CH_C) begin
			if (p == CH_S || p == CH_Z) begin
				o = one_code(4'd8);
			end else begin
				o = one_code((n == CH_A || n == CH_O || n == CH_U || n == CH_H ||
					n == CH_K || n == CH_X || n == CH_Q) ? 4'd4 : 4'd8);
			end
		end else if (c == CH_H) begin
			o = one_code(RAW_H);
		end else if (c == CH_A || c == CH_E || c == CH_I || c == CH_J || c == CH_Y ||
			c == CH_O || c == CH_U) begin
			o = one_code(4'd0);
		end else if (c == CH_B || c == CH_P) begin
			o = one_code(4'd1);
		end else if (c == CH_F || c == CH_V || c == CH_W) begin
			o = one_code(4'd3);
		end else if (c == CH_G || c == CH_K || c == CH_Q) begin
			o = one_code(4'd4);
		end else if (c == CH_L) begin
			o = one_code(4'd5);
		end else if (c == CH_R) begin
			o = one_code(4'd7);
		end else if (c == CH_M || c == CH_N) begin
			o = one_code(4'd6);
		end else if (c == CH_S || c == CH_Z) begin
			o = one_code(4'd8);
		end
		return o;
	endfunction

	// collapse repeats, drop H marks and non-leading zeros, hold newest digit
	function automatic feed_out_t feed(input filt_t s, input logic [3:0] raw,
		input logic en);
		feed_out_t o;
		o.st    = s;
		o.emit  = 1'b0;
		o.digit = s.held_digit;
		if (en && raw != s.last_raw) begin
			o.st.last_raw = raw;
			if (raw != RAW_H && !(s.first_seen && raw == 4'd0)) begin
				o.st.first_seen = 1'b1;
				o.emit          = s.held_valid;
				o.st.held_digit = raw;
				o.st.held_valid = 1'b1;
			end
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cologne_phonetic_encoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cologne_phonetic_encoder_unit
// Cologne phonetic coder: one character per request in, code digits out,
// the last digit of a word flagged by tlast.
// ----------------------------------------------------------------------------
// First result of a request is registered, valid in the cycle after acceptance.
// Throughput: a request yields k results (0..4) and holds the result stage
// until they drain; one request per cycle while each yields <= 1 and m_tready is high.
// The four-slot result register is drained one per cycle while m_tready is high.
// Reset: word window blank, filter state cleared, result stage empty.
module cologne_phonetic_encoder_unit
	import cpe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] char_in
	input  wire logic       s_tlast,  // word_end
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // [3:0] code_digit, [7:4] zero
	output logic            m_tuser,  // is_empty
	output logic            m_tlast   // code_end
);

	logic [7:0] prev_q, cur_q;
	logic       have_q, start_q;
	filt_t      filt_q;

	result_t    res_s1 [RES_SLOTS];
	logic [2:0] cnt_s1;

	logic       acc, pop;
	logic [7:0] n_ch, p2;
	logic       start2, n_is_x;
	raw_pair_t  c1, c2;
	feed_out_t  f0, f1, f2;
	result_t    cand   [RES_SLOTS];
	logic       cand_v [RES_SLOTS];
	result_t    packed_res [RES_SLOTS];
	logic [2:0] nres;

	assign pop      = m_tvalid && m_tready;
	assign s_tready = (cnt_s1 == 3'd0) || (cnt_s1 == 3'd1 && m_tready);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		n_ch   = fold(s_tdata);
		n_is_x = (n_ch == CH_X);
		p2     = have_q ? cur_q : prev_q;
		start2 = have_q ? 1'b0 : start_q;
		c1 = '{cnt: 2'd0, r0: 4'd0, r1: 4'd0};
		if (have_q && cur_q != CH_X) begin
			c1 = code_char(prev_q, cur_q, n_ch, start_q);
		end
		c2 = '{cnt: 2'd0, r0: 4'd0, r1: 4'd0};
		if (n_is_x) begin
			c2 = code_char(p2, n_ch, CH_BLANK, 1'b0);
		end else if (s_tlast) begin
			c2 = code_char(p2, n_ch, CH_BLANK, start2);
		end
		f0 = feed(filt_q, c1.r0, c1.cnt != 2'd0);
		f1 = feed(f0.st, c2.r0, c2.cnt != 2'd0);
		f2 = feed(f1.st, c2.r1, c2.cnt == 2'd2);

		cand[0] = '{digit: f0.digit, is_empty: 1'b0, code_end: 1'b0};
		cand[1] = '{digit: f1.digit, is_empty: 1'b0, code_end: 1'b0};
		cand[2] = '{digit: f2.digit, is_empty: 1'b0, code_end: 1'b0};
		cand[3] = '{digit: f2.st.held_valid ? f2.st.held_digit : 4'd0,
			is_empty: !f2.st.held_valid, code_end: 1'b1};
		cand_v[0] = f0.emit;
		cand_v[1] = f1.emit;
		cand_v[2] = f2.emit;
		cand_v[3] = s_tlast;

		nres = 3'd0;
		for (int i = 0; i < RES_SLOTS; i++) begin
			packed_res[i] = cand[3];
		end
		for (int i = 0; i < RES_SLOTS; i++) begin
			if (cand_v[i]) begin
				packed_res[nres[1:0]] = cand[i];
				nres = nres + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= CH_BLANK;
			cur_q   <= CH_BLANK;
			have_q  <= 1'b0;
			start_q <= 1'b1;
			filt_q  <= FILT_RESET;
			cnt_s1  <= 3'd0;
		end else begin
			if (acc) begin
				cnt_s1 <= nres;
				if (s_tlast) begin
					prev_q  <= CH_BLANK;
					cur_q   <= CH_BLANK;
					have_q  <= 1'b0;
					start_q <= 1'b1;
					filt_q  <= FILT_RESET;
				end else begin
					prev_q  <= p2;
					cur_q   <= n_ch;
					have_q  <= 1'b1;
					start_q <= start2;
					filt_q  <= f2.st;
				end
			end else if (pop) begin
				cnt_s1 <= cnt_s1 - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < RES_SLOTS; i++) begin
				res_s1[i] <= packed_res[i];
			end
		end else if (pop) begin
			for (int i = 0; i < RES_SLOTS - 1; i++) begin
				res_s1[i] <= res_s1[i + 1];
			end
		end
	end

	assign m_tvalid = (cnt_s1 != 3'd0);
	assign m_tdata  = {4'd0, res_s1[0].digit};
	assign m_tuser  = res_s1[0].is_empty;
	assign m_tlast  = res_s1[0].code_end;

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (cnt_s1 <= 3'd1))
		else $error("input taken while result stage still holds several results");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata[3:0] == 4'd0))
		else $error("empty-word result without end flag or with a digit");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] <= 4'd8))
		else $error("code digit out of range");

	a_word_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tlast) |=> (!have_q && !filt_q.held_valid && start_q && m_tvalid))
		else $error("word state not cleared or no result after word end");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the Cologne phonetic coder. Words go in one character per request
// and the code digits coming out are compared with a behavioral model of the
// coding rules. Both stream sides stall at random. The output is also held
// off for a long stretch so that the coder backs up.
// ----------------------------------------------------------------------------
module testbench
	import cpe_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PRINT_CAP      = 40;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	cologne_phonetic_encoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stall settings: idle chances in percent of cycles, and a requested output hold-off
	int snd_idle_pct = 22;
	int rcv_idle_pct = 79;
	int rcv_hold_req = 0;

	int errors       = 0;
	int chars_sent   = 0;
	int words_sent   = 0;
	int digits_seen  = 0;
	int idle_cycles  = 0;

	result_t pending_codes[$];

	// coder model state
	logic [7:0] prv_ch;
	logic [7:0] cur_ch;
	bit         have_cur;
	bit         word_start;
	logic [3:0] last_raw;
	bit         first_seen;
	logic [3:0] held_dig;
	bit         held_ok;
	int         step_results;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
			return c - CASE_OFS;
		end
		return c;
	endfunction

	function automatic bit one_of(input logic [7:0] c, input string letters);
		for (int i = 0; i < letters.len(); i++) begin
			if (letters[i] == c) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// raw codes for character c seen between p and n; returns how many
	function automatic int raw_codes(input logic [7:0] p, input logic [7:0] c,
		input logic [7:0] n, input bit lead, output logic [3:0] r0, output logic [3:0] r1);
		r0 = 4'd0;
		r1 = 4'd0;
		if (lead && c == CH_C) begin
			r0 = one_of(n, "AHKLOQRUX") ? 4'd4 : 4'd8;
			return 1;
		end
		if (c == CH_P && n == CH_H) begin
			r0 = 4'd3;
			return 1;
		end
		if (c == CH_D || c == CH_T) begin
			r0 = one_of(n, "CSZ") ? 4'd8 : 4'd2;
			return 1;
		end
		if (c == CH_X) begin
			if (one_of(p, "CKQ")) begin
				r0 = 4'd8;
				return 1;
			end
			r0 = 4'd4;
			r1 = 4'd8;
			return 2;
		end
		if (c == CH_C) begin
			if (p == CH_S || p == CH_Z) begin
				r0 = 4'd8;
			end else begin
				r0 = one_of(n, "AOUHKXQ") ? 4'd4 : 4'd8;
			end
			return 1;
		end
		if (c == CH_H) begin
			r0 = RAW_H;
			return 1;
		end
		case (1'b1)
			one_of(c, "AEIJYOU"): r0 = 4'd0;
			one_of(c, "BP"):      r0 = 4'd1;
			one_of(c, "FVW"):     r0 = 4'd3;
			one_of(c, "GKQ"):     r0 = 4'd4;
			one_of(c, "L"):       r0 = 4'd5;
			one_of(c, "MN"):      r0 = 4'd6;
			one_of(c, "R"):       r0 = 4'd7;
			one_of(c, "SZ"):      r0 = 4'd8;
			default:              return 0;
		endcase
		return 1;
	endfunction

	task automatic expect_code(input logic [3:0] digit, input bit empty, input bit fin);
		result_t r;
		if (step_results >= RES_SLOTS) begin
			return;
		end
		r.digit    = digit;
		r.is_empty = empty;
		r.code_end = fin;
		pending_codes.push_back(r);
		step_results++;
	endtask

	task automatic filter_raw(input logic [3:0] raw);
		if (raw == last_raw) begin
			return;
		end
		last_raw = raw;
		if (raw == RAW_H || (first_seen && raw == 4'd0)) begin
			return;
		end
		first_seen = 1'b1;
		if (held_ok) begin
			expect_code(held_dig, 1'b0, 1'b0);
		end
		held_dig = raw;
		held_ok  = 1'b1;
	endtask

	task automatic code_window(input logic [7:0] p, input logic [7:0] c,
		input logic [7:0] n, input bit lead);
		logic [3:0] r0;
		logic [3:0] r1;
		int k;
		k = raw_codes(p, c, n, lead, r0, r1);
		if (k > 0) begin
			filter_raw(r0);
		end
		if (k > 1) begin
			filter_raw(r1);
		end
	endtask

	task automatic clear_word();
		prv_ch     = CH_BLANK;
		cur_ch     = CH_BLANK;
		have_cur   = 1'b0;
		word_start = 1'b1;
		last_raw   = RAW_NONE;
		first_seen = 1'b0;
		held_dig   = 4'd0;
		held_ok    = 1'b0;
	endtask

	task automatic predict_char(input logic [7:0] ch, input bit fin);
		logic [7:0] n;
		n = upcase(ch);
		step_results = 0;
		if (have_cur) begin
			if (cur_ch != CH_X) begin
				code_window(prv_ch, cur_ch, n, word_start);
			end
			prv_ch     = cur_ch;
			word_start = 1'b0;
		end
		cur_ch   = n;
		have_cur = 1'b1;
		// X is coded on arrival, its code only looks back
		if (n == CH_X) begin
			code_window(prv_ch, n, CH_BLANK, 1'b0);
		end
		if (fin) begin
			if (cur_ch != CH_X) begin
				code_window(prv_ch, cur_ch, CH_BLANK, word_start);
			end
			if (held_ok) begin
				expect_code(held_dig, 1'b0, 1'b1);
			end else begin
				expect_code(4'd0, 1'b1, 1'b1);
			end
			clear_word();
		end
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		if (errors < PRINT_CAP) begin
			$display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
		end
		errors++;
	endtask

	task automatic send_char(input logic [7:0] ch, input bit fin);
		if ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < snd_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= fin;
		do begin
			@(posedge clk);
		end while (!s_tready);
		predict_char(ch, fin);
		chars_sent++;
		if (fin) begin
			words_sent++;
		end
	endtask

	task automatic send_text(input string w);
		for (int i = 0; i < w.len(); i++) begin
			send_char(w[i], i == w.len() - 1);
		end
	endtask

	function automatic logic [7:0] pick_char();
		int sel;
		logic [7:0] c;
		string tricky;
		tricky = "CXHPDTSZKQ";
		sel = $urandom_range(99);
		if (sel < 8) begin
			return 8'($urandom_range(255));
		end
		if (sel < 35) begin
			c = tricky[$urandom_range(tricky.len() - 1)];
		end else begin
			c = CH_A + 8'($urandom_range(25));
		end
		if ($urandom_range(1) == 1) begin
			c = c + CASE_OFS;
		end
		return c;
	endfunction

	task automatic send_random_word();
		int len;
		bit noise;
		len   = $urandom_range(1, 10);
		noise = ($urandom_range(99) < 8);
		for (int i = 0; i < len; i++) begin
			send_char(noise ? 8'($urandom_range(255)) : pick_char(), i == len - 1);
		end
	endtask

	task automatic wait_codes_done();
		do begin
			@(posedge clk);
		end while (pending_codes.size() != 0);
	endtask

	// checker: every accepted digit against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			digits_seen++;
			if (pending_codes.size() == 0) begin
				report_mismatch("unexpected result, tdata", m_tdata, -1);
			end else begin
				want = pending_codes.pop_front();
				if (m_tdata !== {4'd0, want.digit}) begin
					report_mismatch("code digit", m_tdata, want.digit);
				end
				if (m_tuser !== want.is_empty) begin
					report_mismatch("empty flag", m_tuser, want.is_empty);
				end
				if (m_tlast !== want.code_end) begin
					report_mismatch("end flag", m_tlast, want.code_end);
				end
			end
		end
	end

	// output side: random stalls, plus a counted hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rcv_hold_req != 0) begin
				hold_left    = rcv_hold_req;
				rcv_hold_req = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_coding_rules();
		// X at word start, PH, T before Z, lowercase input
		send_text("xPhTz");
		// C at start before D, D before S, C after S, trailing H
		send_text("Cdsch");
		// X after K, C before U
		send_text("kXacu");
		// no letters at all: NUL and a non-ASCII byte
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		// only a separator mark
		send_text("h");
		send_text("Ax");
	endtask

	task automatic test_random_words(input int n_chars);
		int goal;
		goal = chars_sent + n_chars;
		while (chars_sent < goal) begin
			send_random_word();
		end
	endtask

	task automatic test_output_hold_off();
		rcv_hold_req = HOLD_CYCLES;
		repeat (6) begin
			send_random_word();
		end
	endtask

	task automatic test_sender_pause();
		send_random_word();
		send_char(CH_S, 1'b0);
		s_tvalid <= 1'b0;
		wait_codes_done();
		send_char(CH_C, 1'b0);
		send_char(CH_H, 1'b1);
	endtask

	initial begin
		clear_word();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_coding_rules();
		test_random_words(110);

		snd_idle_pct = 79;
		rcv_idle_pct = 22;
		test_output_hold_off();
		test_random_words(110);
		test_sender_pause();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_words(110);

		s_tvalid <= 1'b0;
		wait_codes_done();
		repeat (12) @(posedge clk);

		$display("covered %0d characters in %0d words, %0d code digits checked,",
			chars_sent, words_sent, digits_seen);
		$display("with stalls on both sides and a %0d cycle output hold-off", HOLD_CYCLES);
		if (errors == 0 && pending_codes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_codes.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
